>>> rtl/core/mlf_pkg.sv
// Shared constants and types of the queued mutex.
`timescale 1ns / 1ps

package mlf_pkg;

    // Default sizes
    localparam int MAX_WAITERS_DEF    = 16;
    localparam int THREAD_ID_BITS_DEF = 8;

    // Depth of the command queue between front and back
    localparam int CQ_DEPTH = 2;

    localparam int STATUS_W = 3;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_GRANTED = 3'd0;
    localparam t_status ST_QUEUED  = 3'd1;
    localparam t_status ST_HANDED  = 3'd2;
    localparam t_status ST_FREED   = 3'd3;
    localparam t_status ST_IGNORED = 3'd4;
    localparam t_status ST_FULL    = 3'd5;

    // Request kinds
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Command queue occupancy
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Lock state seen by the top level
    typedef struct packed {
        logic free;
        logic waiters;
    } t_lock_stat;

endpackage

>>> rtl/core/mlf_front.sv
// Request front end: accept, decode and forward commands to the queue.
`timescale 1ns / 1ps

module mlf_front import mlf_pkg::*; #(
    parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_req_type,
    input  logic [THREAD_ID_BITS-1:0] i_thread_id,
    input  t_q_stat                   i_q_stat,
    output logic                      o_push,
    output logic                      o_is_rel,
    output logic [THREAD_ID_BITS-1:0] o_id
);

    logic                      r_valid;
    logic                      n_valid;
    logic                      r_is_rel;
    logic [THREAD_ID_BITS-1:0] r_id;
    logic                      accept;

    assign o_push     = r_valid && !i_q_stat.full;
    assign o_in_stall = r_valid && i_q_stat.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_is_rel   = r_is_rel;
    assign o_id       = r_id;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Decode the request kind on transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_rel <= (i_req_type == OP_RELEASE);
            r_id     <= i_thread_id;
        end
    end

endmodule

>>> rtl/core/mlf_cmd_q.sv
// Short command queue between the front end and the lock engine.
`timescale 1ns / 1ps

module mlf_cmd_q import mlf_pkg::*; #(
    parameter int WIDTH = 1 + THREAD_ID_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    localparam int PTR_W = $clog2(CQ_DEPTH);
    localparam int CNT_W = $clog2(CQ_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [CQ_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;
    logic [CNT_W-1:0] n_cnt;

    assign o_stat.full  = (r_cnt == CNT_W'(CQ_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_slot[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(CQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(CQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/core/mlf_back.sv
// Lock engine: owner state, waiter memory and result register.
`timescale 1ns / 1ps

module mlf_back import mlf_pkg::*; #(
    parameter int MAX_WAITERS    = MAX_WAITERS_DEF,
    parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_is_rel,
    input  logic [THREAD_ID_BITS-1:0] i_cmd_id,
    input  t_q_stat                   i_q_stat,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_status                   o_status,
    output logic                      o_woken_valid,
    output logic [THREAD_ID_BITS-1:0] o_woken_id,
    output logic                      o_lock_is_free,
    output logic [THREAD_ID_BITS-1:0] o_owner_id,
    output t_lock_stat                o_lock_stat
);

    localparam int IDX_W = $clog2(MAX_WAITERS);
    localparam int CNT_W = $clog2(MAX_WAITERS + 1);

    localparam logic S_EXEC = 1'b0;
    localparam logic S_HAND = 1'b1;

    logic [THREAD_ID_BITS-1:0] r_mem [MAX_WAITERS];
    logic [THREAD_ID_BITS-1:0] r_rd_data;

    logic                      r_state, n_state;
    logic                      r_free,  n_free;
    logic [THREAD_ID_BITS-1:0] r_owner, n_owner;
    logic [IDX_W-1:0]          r_head,  n_head;
    logic [IDX_W-1:0]          r_tail,  n_tail;
    logic [CNT_W-1:0]          r_count, n_count;

    logic                      r_out_valid, n_out_valid;
    t_status                   r_status,    n_status;
    logic                      r_woken_v,   n_woken_v;
    logic [THREAD_ID_BITS-1:0] r_woken_id,  n_woken_id;
    logic                      mem_we;
    logic                      slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_woken_valid  = r_woken_v;
    assign o_woken_id     = r_woken_id;
    assign o_lock_is_free = r_free;
    assign o_owner_id     = r_owner;

    assign o_lock_stat.free    = r_free;
    assign o_lock_stat.waiters = (r_count != '0);

    always_comb begin
        n_state     = r_state;
        n_free      = r_free;
        n_owner     = r_owner;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_woken_v   = r_woken_v;
        n_woken_id  = r_woken_id;
        mem_we      = 1'b0;
        o_pop       = 1'b0;

        unique case (r_state)
            S_EXEC: begin
                if (!i_q_stat.empty && slot_free) begin
                    o_pop      = 1'b1;
                    n_woken_v  = 1'b0;
                    n_woken_id = '0;
                    if (!i_cmd_is_rel) begin
                        n_out_valid = 1'b1;
                        if (r_free) begin
                            n_free   = 1'b0;
                            n_owner  = i_cmd_id;
                            n_status = ST_GRANTED;
                        end else if (r_count == CNT_W'(MAX_WAITERS)) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we   = 1'b1;
                            n_tail   = (r_tail == IDX_W'(MAX_WAITERS - 1)) ?
                                       '0 : r_tail + 1'b1;
                            n_count  = r_count + 1'b1;
                            n_status = ST_QUEUED;
                        end
                    end else if (r_free || r_owner != i_cmd_id) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_IGNORED;
                    end else if (r_count != '0) begin
                        // head entry is read into r_rd_data this cycle
                        n_state = S_HAND;
                    end else begin
                        n_out_valid = 1'b1;
                        n_free      = 1'b1;
                        n_owner     = '0;
                        n_status    = ST_FREED;
                    end
                end
            end
            S_HAND: begin
                if (slot_free) begin
                    n_state     = S_EXEC;
                    n_out_valid = 1'b1;
                    n_owner     = r_rd_data;
                    n_head      = (r_head == IDX_W'(MAX_WAITERS - 1)) ?
                                  '0 : r_head + 1'b1;
                    n_count     = r_count - 1'b1;
                    n_status    = ST_HANDED;
                    n_woken_v   = 1'b1;
                    n_woken_id  = r_rd_data;
                end
            end
            default: begin
                n_state = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_EXEC;
            r_free      <= 1'b1;
            r_owner     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_owner     <= n_owner;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_woken_v  <= n_woken_v;
        r_woken_id <= n_woken_id;
    end

    // Waiter memory: write at the tail, registered read at the head
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= i_cmd_id;
        end
        r_rd_data <= r_mem[r_head];
    end

endmodule

>>> rtl/core/mutex_lock_fifo_handoff.sv
// Top level of the hardware mutex with a first-in first-out waiter queue.
`timescale 1ns / 1ps
//
// Usage
//   Input channel : i_in_valid / o_in_stall with i_req_type (0 acquire,
//                   1 release) and i_thread_id. A transfer happens on a
//                   rising edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall with o_status,
//                   o_woken_valid, o_woken_id, o_lock_is_free, o_owner_id.
//                   Exactly one result is produced per request, in order.
//   Path          : a request passes the front register, then the command
//                   queue, then the result register; a release that hands
//                   the lock to a waiter also passes the S_HAND state, as
//                   the waiter memory is read through a registered port.
//   Throughput    : one request per cycle while no stall holds the flow; a
//                   handoff holds the lock engine in S_EXEC and then S_HAND.
//   Reset         : i_rst_n low at a clock edge frees the lock, clears the
//                   owner and empties the waiter queue and command queue.
//                   The waiter memory itself is not cleared.
//   Stall         : while i_out_stall is high the result register holds;
//                   the two-entry command queue then fills and o_in_stall
//                   rises once the front register has nowhere to go.
//
module mutex_lock_fifo_handoff import mlf_pkg::*; #(
    parameter int MAX_WAITERS    = MAX_WAITERS_DEF,
    parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_req_type,
    input  logic [THREAD_ID_BITS-1:0] i_thread_id,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [STATUS_W-1:0]       o_status,
    output logic                      o_woken_valid,
    output logic [THREAD_ID_BITS-1:0] o_woken_id,
    output logic                      o_lock_is_free,
    output logic [THREAD_ID_BITS-1:0] o_owner_id
);

    localparam int CMD_W = 1 + THREAD_ID_BITS;

    // front to queue
    logic                      fe_push;
    logic                      fe_is_rel;
    logic [THREAD_ID_BITS-1:0] fe_id;

    // queue to back
    t_q_stat                   q_stat;
    logic [CMD_W-1:0]          q_data;
    logic                      bk_pop;
    t_lock_stat                lock_stat;

    // Accept and decode requests; hold in the front register when the
    // command queue is full
    mlf_front #(
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_thread_id (i_thread_id),
        .i_q_stat    (q_stat),
        .o_push      (fe_push),
        .o_is_rel    (fe_is_rel),
        .o_id        (fe_id)
    );

    // Decouple the front from the lock engine
    mlf_cmd_q #(
        .WIDTH (CMD_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  ({fe_is_rel, fe_id}),
        .i_pop   (bk_pop),
        .o_data  (q_data),
        .o_stat  (q_stat)
    );

    // Carry out grant, queue, handoff and free against the lock state
    mlf_back #(
        .MAX_WAITERS    (MAX_WAITERS),
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_is_rel   (q_data[CMD_W-1]),
        .i_cmd_id       (q_data[THREAD_ID_BITS-1:0]),
        .i_q_stat       (q_stat),
        .o_pop          (bk_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_woken_valid  (o_woken_valid),
        .o_woken_id     (o_woken_id),
        .o_lock_is_free (o_lock_is_free),
        .o_owner_id     (o_owner_id),
        .o_lock_stat    (lock_stat)
    );

    // Waiters exist only while the lock is held
    a_waiters_hold_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lock_stat.waiters |-> !lock_stat.free)
        else $error("waiters queued on a free lock");

    // A woken thread is reported with a handoff and with nothing else
    a_woken_on_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_woken_valid == (o_status == ST_HANDED)))
        else $error("woken flag does not match handoff status");

    // A free lock reports no owner
    a_free_no_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_lock_is_free) |-> (o_owner_id == '0))
        else $error("free lock reports an owner");

    // Grant, queue and handoff all leave the lock held
    a_held_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_GRANTED || o_status == ST_QUEUED ||
                         o_status == ST_HANDED)) |-> !o_lock_is_free)
        else $error("lock free after a grant, queue or handoff");

    // Never pop from an empty command queue
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

endmodule

>>> dv/tb.sv
// Self-checking testbench for the queued mutex with waiter handoff.
`timescale 1ns / 1ps

module tb;
    import mlf_pkg::*;

    localparam int MAX_WAITERS  = MAX_WAITERS_DEF;
    localparam int ID_BITS      = THREAD_ID_BITS_DEF;
    localparam int RANDOM_REQS  = 1100;
    // Cycles without any transfer before the run is declared hung
    localparam int HANG_LIMIT   = 2000;
    // Cycles to wait after the last result
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_PCT     = 34;

    typedef logic [ID_BITS-1:0] t_tid;

    // One result of the lock engine, as seen on the output channel
    typedef struct packed {
        t_status status;
        logic    woken_valid;
        t_tid    woken_id;
        logic    lock_free;
        t_tid    owner;
    } t_lock_outcome;

    // Tracks the lock, its owner and the waiter queue, and holds the
    // outcomes still to arrive, oldest first.
    class t_lock_ledger;
        bit            lock_free;
        t_tid          owner;
        t_tid          waiters [MAX_WAITERS];
        int            head;
        int            tail;
        int            waiting;
        t_lock_outcome outcomes_due [$];
        int            errors;

        function new();
            lock_free = 1'b1;
            owner     = '0;
            head      = 0;
            tail      = 0;
            waiting   = 0;
            errors    = 0;
        endfunction

        function void log_request(logic op, t_tid id);
            t_lock_outcome r;
            r.woken_valid = 1'b0;
            r.woken_id    = '0;
            if (op == OP_ACQUIRE) begin
                if (lock_free) begin
                    lock_free = 1'b0;
                    owner     = id;
                    r.status  = ST_GRANTED;
                end else if (waiting >= MAX_WAITERS) begin
                    r.status = ST_FULL;
                end else begin
                    // The owner itself queues like anybody else
                    waiters[tail] = id;
                    tail          = (tail + 1) % MAX_WAITERS;
                    waiting++;
                    r.status = ST_QUEUED;
                end
            end else if (lock_free || owner != id) begin
                // A free lock has no owner, whatever the stale owner value
                r.status = ST_IGNORED;
            end else if (waiting > 0) begin
                owner = waiters[head];
                head  = (head + 1) % MAX_WAITERS;
                waiting--;
                r.woken_valid = 1'b1;
                r.woken_id    = owner;
                r.status      = ST_HANDED;
            end else begin
                lock_free = 1'b1;
                owner     = '0;
                r.status  = ST_FREED;
            end
            r.lock_free = lock_free;
            r.owner     = lock_free ? t_tid'(0) : owner;
            outcomes_due.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_result(t_lock_outcome got);
            t_lock_outcome want;
            if (outcomes_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, got.status);
                errors++;
                return;
            end
            want = outcomes_due.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("woken_valid", want.woken_valid, got.woken_valid);
            compare_field("woken_id", want.woken_id, got.woken_id);
            compare_field("lock_is_free", want.lock_free, got.lock_free);
            compare_field("owner_id", want.owner, got.owner);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic        i_req_type  = OP_ACQUIRE;
    t_tid        i_thread_id = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_status     o_status;
    logic        o_woken_valid;
    t_tid        o_woken_id;
    logic        o_lock_is_free;
    t_tid        o_owner_id;

    t_lock_ledger ledger = new();
    int           sent   = 0;
    int           stuck  = 0;

    mutex_lock_fifo_handoff DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_thread_id    (i_thread_id),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_woken_valid  (o_woken_valid),
        .o_woken_id     (o_woken_id),
        .o_lock_is_free (o_lock_is_free),
        .o_owner_id     (o_owner_id)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Both sides run without any idling for a long stretch in the middle
    function automatic int idle_pct();
        return (sent >= 500 && sent < 720) ? 0 : IDLE_PCT;
    endfunction

    // Favour the extreme ids now and then so both ends of the range are hit
    function automatic t_tid pick_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return '1;
        return t_tid'($urandom_range(0, (1 << ID_BITS) - 1));
    endfunction

    // Offer one request and hold it until the block takes the transfer.
    // Valid is only lowered inside an idle gap, so it never gets two
    // assignments in one time step.
    task automatic issue_request(input logic op, input t_tid id);
        while ($urandom_range(0, 99) < idle_pct()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= op;
        i_thread_id <= id;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        ledger.log_request(op, id);
        sent++;
    endtask

    // Check every result transfer, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            ledger.match_result('{o_status, o_woken_valid, o_woken_id,
                                  o_lock_is_free, o_owner_id});
        i_out_stall <= ($urandom_range(0, 99) < idle_pct());
    end

    // Abort when neither channel has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck = 0;
        else
            stuck++;
        if (stuck >= HANG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_tid queue_ids [15];
        logic op;
        t_tid id;
        int   roll;
        int   acq_bias;

        queue_ids = '{8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
                      8'h80, 8'h7F, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB};
        acq_bias = 45;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Release of a free lock whose stale owner value matches the id
        issue_request(OP_RELEASE, 8'h00);
        // Grant to thread 0, then let the owner queue behind itself
        issue_request(OP_ACQUIRE, 8'h00);
        issue_request(OP_ACQUIRE, 8'h00);
        // Fill the waiter queue, then overflow it
        foreach (queue_ids[k])
            issue_request(OP_ACQUIRE, queue_ids[k]);
        issue_request(OP_ACQUIRE, 8'hAA);
        // Release by a stranger, then the owner hands the lock to itself
        issue_request(OP_RELEASE, 8'h55);
        issue_request(OP_RELEASE, 8'h00);

        // Mostly well-formed traffic: owners release, others queue. Shift the
        // balance every hundred requests so the queue both drains and fills.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       acq_bias = 25;
                    1:       acq_bias = 45;
                    default: acq_bias = 70;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (ledger.lock_free) begin
                op = (roll < 90) ? OP_ACQUIRE : OP_RELEASE;
                id = pick_id();
            end else if (roll < acq_bias) begin
                op = OP_ACQUIRE;
                id = ($urandom_range(0, 9) == 0) ? ledger.owner : pick_id();
            end else if (roll < acq_bias + (100 - acq_bias) * 8 / 10) begin
                op = OP_RELEASE;
                id = ledger.owner;
            end else begin
                op = OP_RELEASE;
                id = pick_id();
            end
            issue_request(op, id);
        end
        i_in_valid <= 1'b0;

        // Wait for the outstanding results, then give stray ones time to show
        while (ledger.outcomes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (ledger.outcomes_due.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, ledger.outcomes_due.size());
            ledger.errors++;
        end
        if (ledger.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> mutex_lock_fifo_handoff.f
rtl/core/mlf_pkg.sv
rtl/core/mlf_front.sv
rtl/core/mlf_cmd_q.sv
rtl/core/mlf_back.sv
rtl/core/mutex_lock_fifo_handoff.sv
dv/tb.sv
